FILE: design/pidc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, codes and saturation helpers of the PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned LimW    = 31;
  localparam int unsigned ModeW   = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivCntW = 5;   // 32 quotient bits

  localparam logic [LimW-1:0] RampReset = 31'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_OUT_LIMIT  = 3'd3,
    REG_INT_LIMIT  = 3'd4,
    REG_RAMP_WIDTH = 3'd5,
    REG_FULL_BAND  = 3'd6,
    REG_MODE       = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_CHECK, ST_RMUL, ST_DSTART, ST_DSTEP, ST_DFIN,
    ST_MI, ST_MP, ST_MD, ST_FIN, ST_CLR
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PREP, OP_CHECK, OP_RMUL, OP_DSTART, OP_DSTEP,
    OP_DFIN, OP_MI, OP_MP, OP_MD, OP_FIN, OP_CLR
  } dp_op_t;

  typedef struct packed {
    logic is_clear;
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) r = x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else r = x[31:0];
    return r;
  endfunction

  // floor(x / 65536) saturated to 32 bits
  function automatic logic signed [31:0] qsat(input logic signed [63:0] x);
    logic signed [47:0] s;
    logic signed [31:0] r;
    s = x[63:16];
    if (s > 48'sd2147483647) r = 32'sh7fff_ffff;
    else if (s < -48'sd2147483648) r = 32'sh8000_0000;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clampsym(input logic signed [33:0] x,
                                                  input logic [LimW-1:0] lim);
    logic signed [33:0] l;
    logic signed [33:0] r;
    l = signed'({3'b000, lim});
    if (x > l) r = l;
    else if (x < -l) r = -l;
    else r = x;
    return r[31:0];
  endfunction

endpackage

FILE: design/pidc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_in_if / pidc_out_if
// Valid/ready channels carrying update words and drive words.
// ----------------------------------------------------------------------------
interface pidc_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] measured;
  logic signed [31:0] setpoint;
  modport source (output valid, command, measured, setpoint, input ready);
  modport sink   (input valid, command, measured, setpoint, output ready);
endinterface

interface pidc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

FILE: design/pid_controller_with_integral_options.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_with_integral_options
// Q16.16 positional PID with trapezoid, variable-rate and anti-windup options.
// ----------------------------------------------------------------------------
// Update word: PREP, CHECK, MI, MP, MD, FIN; the variable-rate ramp scaling adds
// RMUL and a serial divider (one quotient bit per cycle) before MI.
// Clear word: PREP, CLR. One word in flight; next word accepted once done.
// Synchronous reset clears state and loads register defaults; no sweep.
module pid_controller_with_integral_options (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  pidc_in_if.sink     req,
  pidc_out_if.source  rsp
);

  pidc_pkg::dp_op_t     op;
  pidc_pkg::dp_status_t st;

  pidc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .op       (op)
  );

  pidc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (req.command),
    .measured  (req.measured),
    .setpoint  (req.setpoint),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .drive     (rsp.drive),
    .op        (op),
    .st        (st)
  );

endmodule

FILE: design/pidc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_ctrl
// Sequencer: steps the datapath through one update or clear word.
// ----------------------------------------------------------------------------
module pidc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pidc_pkg::dp_status_t st,
  output pidc_pkg::dp_op_t     op
);

  pidc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= pidc_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    op         = pidc_pkg::OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      pidc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = pidc_pkg::OP_LOAD;
          state_next = pidc_pkg::ST_PREP;
        end
      end
      pidc_pkg::ST_PREP: begin
        op         = pidc_pkg::OP_PREP;
        state_next = st.is_clear ? pidc_pkg::ST_CLR : pidc_pkg::ST_CHECK;
      end
      pidc_pkg::ST_CHECK: begin
        op         = pidc_pkg::OP_CHECK;
        state_next = st.need_div ? pidc_pkg::ST_RMUL : pidc_pkg::ST_MI;
      end
      pidc_pkg::ST_RMUL: begin
        op         = pidc_pkg::OP_RMUL;
        state_next = pidc_pkg::ST_DSTART;
      end
      pidc_pkg::ST_DSTART: begin
        op         = pidc_pkg::OP_DSTART;
        state_next = pidc_pkg::ST_DSTEP;
      end
      pidc_pkg::ST_DSTEP: begin
        op = pidc_pkg::OP_DSTEP;
        if (st.div_last) state_next = pidc_pkg::ST_DFIN;
      end
      pidc_pkg::ST_DFIN: begin
        op         = pidc_pkg::OP_DFIN;
        state_next = pidc_pkg::ST_MI;
      end
      pidc_pkg::ST_MI: begin
        op         = pidc_pkg::OP_MI;
        state_next = pidc_pkg::ST_MP;
      end
      pidc_pkg::ST_MP: begin
        op         = pidc_pkg::OP_MP;
        state_next = pidc_pkg::ST_MD;
      end
      pidc_pkg::ST_MD: begin
        op         = pidc_pkg::OP_MD;
        state_next = pidc_pkg::ST_FIN;
      end
      pidc_pkg::ST_FIN: begin
        if (st.out_free) begin
          op         = pidc_pkg::OP_FIN;
          state_next = pidc_pkg::ST_IDLE;
        end
      end
      pidc_pkg::ST_CLR: begin
        if (st.out_free) begin
          op         = pidc_pkg::OP_CLR;
          state_next = pidc_pkg::ST_IDLE;
        end
      end
      default: state_next = pidc_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: design/pidc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_dp
// Datapath: registers, error terms, shared multiplier, serial divider, clamps.
// ----------------------------------------------------------------------------
module pidc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 command,
  input  logic signed [31:0]   measured,
  input  logic signed [31:0]   setpoint,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   drive,
  input  pidc_pkg::dp_op_t     op,
  output pidc_pkg::dp_status_t st
);

  logic signed [31:0] gain_p, gain_i, gain_d;
  logic [30:0]        output_limit, int_limit, ramp_width, full_band;
  logic [pidc_pkg::ModeW-1:0] mode_bits;

  logic signed [31:0] prev_error, prev_measure, integral_sum, prev_drive;
  logic               cmd;
  logic signed [31:0] meas, sp;
  logic signed [31:0] err, d_op, i_op, p_term;
  logic [31:0]        abs_err;
  logic               same;
  logic signed [63:0] prod;
  logic               q_neg;
  logic [31:0]        rem, quo;
  logic [pidc_pkg::DivCntW-1:0] div_cnt;

  // update-step combinational terms
  logic signed [32:0] diff, d_err, d_meas, trap_sum;
  logic signed [31:0] e_c, iop_c;
  logic               same_c;
  logic [31:0]        ramp_top, ramp_num, prev_abs;
  logic               in_band, in_ramp, aw_hit, vr_on;
  logic signed [65:0] mul_full;
  logic signed [32:0] mul_a, mul_b;
  logic [63:0]        prod_mag;
  logic [32:0]        trial;
  logic               ge;
  logic signed [31:0] i_term, d_term;
  logic signed [33:0] drive_sum;

  always_comb begin
    diff     = 33'(sp) - 33'(meas);
    e_c      = pidc_pkg::sat33(diff);
    trap_sum = 33'(e_c) + 33'(prev_error);
    iop_c    = mode_bits[0] ? trap_sum[32:1] : e_c;
    same_c   = (e_c > 0 && integral_sum > 0) || (e_c < 0 && integral_sum < 0);
    d_err    = 33'(e_c) - 33'(prev_error);
    d_meas   = 33'(prev_measure) - 33'(meas);

    ramp_top = {1'b0, ramp_width} + {1'b0, full_band};
    ramp_num = ramp_top - abs_err;
    in_band  = abs_err <= {1'b0, full_band};
    in_ramp  = (abs_err <= ramp_top) && (ramp_width != '0);
    prev_abs = prev_drive[31] ? 32'(-prev_drive) : 32'(prev_drive);
    aw_hit   = mode_bits[2] && same && (prev_abs == {1'b0, output_limit});
    vr_on    = mode_bits[1] && same && !in_band;

    mul_a = 33'(i_op);
    mul_b = signed'({1'b0, ramp_num});
    case (op)
      pidc_pkg::OP_MI: begin mul_a = 33'(gain_i); mul_b = 33'(i_op); end
      pidc_pkg::OP_MP: begin mul_a = 33'(gain_p); mul_b = 33'(err);  end
      pidc_pkg::OP_MD: begin mul_a = 33'(gain_d); mul_b = 33'(d_op); end
      default: ;
    endcase
    mul_full = mul_a * mul_b;

    prod_mag = prod[63] ? 64'(-prod) : 64'(prod);
    trial    = {rem, quo[31]};
    ge       = trial >= {2'b00, ramp_width};

    i_term    = pidc_pkg::qsat(prod);
    d_term    = pidc_pkg::qsat(prod);
    drive_sum = 34'(p_term) + 34'(integral_sum) + 34'(d_term);
  end

  assign st.is_clear = cmd;
  assign st.need_div = vr_on && in_ramp && !aw_hit;
  assign st.div_last = div_cnt == 5'd31;
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= '0;
      gain_i       <= '0;
      gain_d       <= '0;
      output_limit <= '0;
      int_limit    <= '0;
      ramp_width   <= pidc_pkg::RampReset;
      full_band    <= '0;
      mode_bits    <= '0;
    end else if (cfg_we) begin
      unique case (pidc_pkg::reg_idx_t'(cfg_index))
        pidc_pkg::REG_GAIN_P:     gain_p       <= cfg_data;
        pidc_pkg::REG_GAIN_I:     gain_i       <= cfg_data;
        pidc_pkg::REG_GAIN_D:     gain_d       <= cfg_data;
        pidc_pkg::REG_OUT_LIMIT:  output_limit <= cfg_data[30:0];
        pidc_pkg::REG_INT_LIMIT:  int_limit    <= cfg_data[30:0];
        pidc_pkg::REG_RAMP_WIDTH: ramp_width   <= cfg_data[30:0];
        pidc_pkg::REG_FULL_BAND:  full_band    <= cfg_data[30:0];
        pidc_pkg::REG_MODE:       mode_bits    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error   <= '0;
      prev_measure <= '0;
      integral_sum <= '0;
      prev_drive   <= '0;
      out_valid    <= 1'b0;
      div_cnt      <= '0;
    end else begin
      if (op == pidc_pkg::OP_FIN || op == pidc_pkg::OP_CLR) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (op)
        pidc_pkg::OP_LOAD: begin
          cmd  <= command;
          meas <= measured;
          sp   <= setpoint;
        end
        pidc_pkg::OP_PREP: begin
          err     <= e_c;
          abs_err <= e_c[31] ? 32'(-e_c) : 32'(e_c);
          i_op    <= iop_c;
          same    <= same_c;
          d_op    <= pidc_pkg::sat33(mode_bits[3] ? d_meas : d_err);
        end
        pidc_pkg::OP_CHECK: begin
          if (aw_hit || (vr_on && !in_ramp)) i_op <= '0;
        end
        pidc_pkg::OP_RMUL: prod <= mul_full[63:0];
        pidc_pkg::OP_DSTART: begin
          q_neg   <= prod[63];
          rem     <= prod_mag[63:32];
          quo     <= prod_mag[31:0];
          div_cnt <= '0;
        end
        pidc_pkg::OP_DSTEP: begin
          rem     <= ge ? 32'(trial - {2'b00, ramp_width}) : trial[31:0];
          quo     <= {quo[30:0], ge};
          div_cnt <= div_cnt + 5'd1;
        end
        pidc_pkg::OP_DFIN: i_op <= q_neg ? -quo : quo;
        pidc_pkg::OP_MI: prod <= mul_full[63:0];
        pidc_pkg::OP_MP: begin
          integral_sum <= pidc_pkg::clampsym(
              34'(pidc_pkg::sat33(33'(integral_sum) + 33'(i_term))), int_limit);
          prod <= mul_full[63:0];
        end
        pidc_pkg::OP_MD: begin
          p_term <= pidc_pkg::qsat(prod);
          prod   <= mul_full[63:0];
        end
        pidc_pkg::OP_FIN: begin
          drive        <= pidc_pkg::clampsym(drive_sum, output_limit);
          prev_drive   <= pidc_pkg::clampsym(drive_sum, output_limit);
          prev_error   <= err;
          prev_measure <= meas;
        end
        pidc_pkg::OP_CLR: begin
          drive        <= '0;
          prev_drive   <= '0;
          prev_error   <= '0;
          prev_measure <= '0;
          integral_sum <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule
